// ===== sv/slmd_pkg.sv =====
// Shared constants and types for the sync/length message deframer.
// No dependencies; imported by the deframer, its checker and the testbench.
package slmd_pkg;

    localparam int IDX_W = 17;

    typedef logic [7:0]       t_byte;
    typedef logic [IDX_W-1:0] t_idx;

    localparam t_byte SYNC_A = 8'hAA;
    localparam t_byte SYNC_B = 8'h44;
    localparam t_byte SYNC_C = 8'hB5;

    localparam t_idx IDX_SYNC_C   = 17'd2;
    localparam t_idx IDX_LEN_LO   = 17'd6;
    localparam t_idx IDX_LEN_HI   = 17'd7;
    localparam t_idx IDX_HDR_LAST = 17'd23;
    localparam t_idx HEADER_LEN   = 17'd24;
    localparam t_idx CHECK_TAIL   = 17'd3;
    localparam t_idx MAX_LEN_RST  = 17'd16380;

endpackage

// ===== sv/sync_length_message_deframer.sv =====
// The result of an accepted input byte is registered in the output register.
// Throughput: one byte per cycle; input stalls only while the output register is
// held by a stalled downstream. Hunting bytes that do not complete sync give no result.
// Reset (synchronous, active low): hunting, sync window cleared, limit = 16380.
// Sync/length deframer top level; depends on slmd_pkg.
module sync_length_message_deframer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [16:0]          i_cfg_wr_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  slmd_pkg::t_byte      i_in_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output slmd_pkg::t_byte      o_out_byte,
    output slmd_pkg::t_idx       o_byte_index,
    output logic                 o_frame_start,
    output logic                 o_frame_end,
    output logic                 o_length_error
);
    import slmd_pkg::*;

    logic  [15:0] r_sync_window, n_sync_window;
    logic         r_in_frame,    n_in_frame;
    t_idx         r_pos,         n_pos;
    t_byte        r_len_lo,      n_len_lo;
    t_idx         r_msg_len,     n_msg_len;
    t_idx         r_max_len;

    logic         r_valid;
    t_byte        r_out_byte;
    t_idx         r_out_idx;
    logic         r_start, r_end, r_err;

    logic         accept;
    logic         hit;
    logic         emit;
    logic         res_start, res_end, res_err;
    t_idx         idx;
    t_idx         res_idx;
    t_idx         last_idx;

    assign o_stall = r_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    assign hit = (r_sync_window[15:8] == SYNC_A) && (r_sync_window[7:0] == SYNC_B)
                 && (i_in_byte == SYNC_C);
    assign idx      = r_pos + 17'd1;
    assign last_idx = r_msg_len + CHECK_TAIL;

    always_comb begin
        n_sync_window = r_sync_window;
        n_in_frame    = r_in_frame;
        n_pos         = r_pos;
        n_len_lo      = r_len_lo;
        n_msg_len     = r_msg_len;
        emit          = 1'b0;
        res_start     = 1'b0;
        res_end       = 1'b0;
        res_err       = 1'b0;
        res_idx       = idx;
        if (!r_in_frame) begin
            n_sync_window = {r_sync_window[7:0], i_in_byte};
            if (hit) begin
                n_in_frame = 1'b1;
                n_pos      = IDX_SYNC_C;
                emit       = 1'b1;
                res_start  = 1'b1;
                res_idx    = IDX_SYNC_C;
            end
        end else begin
            emit  = 1'b1;
            n_pos = idx;
            if (idx == IDX_LEN_LO) begin
                n_len_lo = i_in_byte;
            end else if (idx == IDX_LEN_HI) begin
                n_msg_len = {1'b0, i_in_byte, r_len_lo} + HEADER_LEN;
            end
            if (idx == IDX_HDR_LAST && r_msg_len > r_max_len) begin
                res_end = 1'b1;
                res_err = 1'b1;
            end else if (idx >= IDX_HDR_LAST && idx >= last_idx) begin
                res_end = 1'b1;
            end
            if (res_end) begin
                n_in_frame    = 1'b0;
                n_sync_window = '0;
                n_pos         = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_window <= '0;
            r_in_frame    <= 1'b0;
            r_pos         <= '0;
            r_len_lo      <= '0;
            r_msg_len     <= '0;
            r_max_len     <= MAX_LEN_RST;
            r_valid       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            if (accept) begin
                r_sync_window <= n_sync_window;
                r_in_frame    <= n_in_frame;
                r_pos         <= n_pos;
                r_len_lo      <= n_len_lo;
                r_msg_len     <= n_msg_len;
            end
            if (!o_stall) begin
                r_valid <= accept & emit;
            end
        end
    end

    // result payload, loaded with the request that produces it
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_byte <= i_in_byte;
            r_out_idx  <= res_idx;
            r_start    <= res_start;
            r_end      <= res_end;
            r_err      <= res_err;
        end
    end

    assign o_valid        = r_valid;
    assign o_out_byte     = r_out_byte;
    assign o_byte_index   = r_out_idx;
    assign o_frame_start  = r_start;
    assign o_frame_end    = r_end;
    assign o_length_error = r_err;

endmodule

// ===== sv/slmd_checker.sv =====
// Port-level checker for sync_length_message_deframer, attached by bind.
// Depends on slmd_pkg and the deframer's port list.
module slmd_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            o_valid,
    input  logic            i_stall,
    input  slmd_pkg::t_byte o_out_byte,
    input  slmd_pkg::t_idx  o_byte_index,
    input  logic            o_frame_start,
    input  logic            o_frame_end,
    input  logic            o_length_error
);
    import slmd_pkg::*;

    a_start_is_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_start |-> o_byte_index == IDX_SYNC_C && o_out_byte == SYNC_C)
        else $error("frame start not on sync byte");

    a_err_at_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_length_error |-> o_frame_end && o_byte_index == IDX_HDR_LAST)
        else $error("length error off header end");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_frame_end) ##1 o_valid |->
            !o_frame_start && o_byte_index == $past(o_byte_index) + 17'd1)
        else $error("frame index did not advance by one");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_byte_index))
        else $error("stalled result changed");

endmodule

bind sync_length_message_deframer slmd_checker u_slmd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_out_byte     (o_out_byte),
    .o_byte_index   (o_byte_index),
    .o_frame_start  (o_frame_start),
    .o_frame_end    (o_frame_end),
    .o_length_error (o_length_error)
);

// ===== tb/tb_sync_length_message_deframer.sv =====
// Testbench for sync_length_message_deframer: random framed byte streams with a bursty
// sender and a stalling receiver, checked against an in-bench deframer model.
// Depends on slmd_pkg and the sync_length_message_deframer RTL.
`timescale 1ns / 100ps

module tb_sync_length_message_deframer;
    import slmd_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_ITEMS  = 140;
    localparam int PHASE_COUNT  = 8;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_BACKLOG = 64;
    localparam int PARTIAL_LEN  = 200;

    typedef struct packed {
        t_byte data;
        t_idx  idx;
        logic  start;
        logic  fin;
        logic  err;
    } t_frame_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [16:0] i_cfg_wr_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_byte       i_in_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_byte       o_out_byte;
    t_idx        o_byte_index;
    logic        o_frame_start;
    logic        o_frame_end;
    logic        o_length_error;

    sync_length_message_deframer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_start  (o_frame_start),
        .o_frame_end    (o_frame_end),
        .o_length_error (o_length_error)
    );

    t_byte       outgoing_bytes[$];
    t_frame_byte expected_frame_bytes[$];

    // deframer model state
    logic [15:0] hunt_window = '0;
    bit          framing = 1'b0;
    t_idx        frame_pos = '0;
    t_byte       len_low = '0;
    t_idx        msg_len = '0;
    t_idx        max_len_limit = MAX_LEN_RST;

    int failures = 0;
    int bytes_sent = 0;
    int frame_bytes_checked = 0;
    int frames_closed = 0;
    int length_errors = 0;
    int limit_writes = 0;
    int phase_items = 0;
    int burst_left = 0;
    int gap_left = 0;
    int cycle_count = 0;
    int rx_cycles = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    function automatic bit deframe_byte(input t_byte b, output t_frame_byte r);
        bit hit;
        r = '0;
        if (!framing) begin
            hit = (hunt_window == {SYNC_A, SYNC_B}) && (b == SYNC_C);
            hunt_window = {hunt_window[7:0], b};
            if (!hit) return 1'b0;
            framing = 1'b1;
            frame_pos = IDX_SYNC_C;
            r.data = b;
            r.idx = frame_pos;
            r.start = 1'b1;
            return 1'b1;
        end
        frame_pos = frame_pos + 17'd1;
        if (frame_pos == IDX_LEN_LO) begin
            len_low = b;
        end else if (frame_pos == IDX_LEN_HI) begin
            msg_len = {1'b0, b, len_low} + HEADER_LEN;
        end
        if (frame_pos == IDX_HDR_LAST && msg_len > max_len_limit) begin
            r.fin = 1'b1;
            r.err = 1'b1;
        end else if (frame_pos >= IDX_HDR_LAST && frame_pos >= t_idx'(msg_len + CHECK_TAIL)) begin
            r.fin = 1'b1;
        end
        r.data = b;
        r.idx = frame_pos;
        if (r.fin) begin
            framing = 1'b0;
            hunt_window = '0;
            frame_pos = '0;
        end
        return 1'b1;
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // request driver: bursts from the pending queue, random gaps between bursts
    always @(posedge i_clk) begin : byte_feed
        t_frame_byte r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                max_len_limit = i_cfg_wr_data;
                limit_writes++;
            end
            if (i_valid && !o_stall) begin
                bytes_sent++;
                if (deframe_byte(i_in_byte, r)) expected_frame_bytes.push_back(r);
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (outgoing_bytes.size() > 0) begin
                    i_valid <= 1'b1;
                    i_in_byte <= outgoing_bytes.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off to back up the block
    always @(posedge i_clk) begin : rx_pacing
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            rx_cycles++;
            if (!hold_done && rx_cycles >= HOLD_AT && outgoing_bytes.size() >= HOLD_BACKLOG) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_mode_left = $urandom_range(20, 200);
                end else begin
                    rx_mode_left--;
                end
                case (rx_mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= ~i_stall;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : frame_check
        t_frame_byte want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_frame_bytes.size() == 0) begin
                $error("unexpected frame byte %h at index %0d", o_out_byte, o_byte_index);
                failures++;
            end else begin
                want = expected_frame_bytes.pop_front();
                frame_bytes_checked++;
                if (want.fin) frames_closed++;
                if (want.err) length_errors++;
                if (o_out_byte !== want.data) begin
                    $error("out_byte: expected %h, got %h", want.data, o_out_byte);
                    failures++;
                end
                if (o_byte_index !== want.idx) begin
                    $error("byte_index: expected %0d, got %0d", want.idx, o_byte_index);
                    failures++;
                end
                if (o_frame_start !== want.start) begin
                    $error("frame_start: expected %b, got %b", want.start, o_frame_start);
                    failures++;
                end
                if (o_frame_end !== want.fin) begin
                    $error("frame_end: expected %b, got %b", want.fin, o_frame_end);
                    failures++;
                end
                if (o_length_error !== want.err) begin
                    $error("length_error: expected %b, got %b", want.err, o_length_error);
                    failures++;
                end
            end
        end
    end

    task automatic push_byte(input t_byte b);
        outgoing_bytes.push_back(b);
        phase_items++;
    endtask

    task automatic push_header_span(input int first_idx, input int last_idx, input int payload);
        for (int k = first_idx; k <= last_idx; k++) begin
            if (k == IDX_LEN_LO) push_byte(payload[7:0]);
            else if (k == IDX_LEN_HI) push_byte(payload[15:8]);
            else push_byte(t_byte'($urandom_range(0, 255)));
        end
    endtask

    task automatic push_frame(input int payload, input int limit);
        int msg_total;
        msg_total = payload + HEADER_LEN;
        push_byte(SYNC_A);
        push_byte(SYNC_B);
        push_byte(SYNC_C);
        push_header_span(3, IDX_HDR_LAST, payload);
        if (msg_total <= limit) begin
            for (int k = HEADER_LEN; k <= msg_total + CHECK_TAIL; k++) begin
                push_byte(t_byte'($urandom_range(0, 255)));
            end
        end
    endtask

    function automatic int pick_payload(input int limit);
        case ($urandom_range(0, 9))
            5: return (limit < 2000) ? int'($urandom_range(0, 65535)) : int'($urandom_range(0, 40));
            6, 7: begin
                if (limit >= HEADER_LEN && limit <= 400)
                    return limit - HEADER_LEN + $urandom_range(0, 1);
                return $urandom_range(0, 40);
            end
            8: return $urandom_range(0, 3);
            9: return $urandom_range(41, 120);
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    task automatic push_random_traffic(input int limit);
        t_byte b;
        if ($urandom_range(0, 9) < 2) begin
            case ($urandom_range(0, 4))
                0: repeat ($urandom_range(1, 4)) push_byte(t_byte'($urandom_range(0, 255)));
                1: begin
                    // sync broken on its last byte
                    b = t_byte'($urandom_range(0, 255));
                    if (b == SYNC_C) b = '0;
                    push_byte(SYNC_A);
                    push_byte(SYNC_B);
                    push_byte(b);
                end
                2: begin
                    push_byte(SYNC_A);
                    push_byte(SYNC_C);
                end
                3: begin
                    push_byte(SYNC_B);
                    push_byte(SYNC_C);
                end
                default: push_byte(SYNC_A);
            endcase
        end else begin
            push_frame(pick_payload(limit), limit);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (outgoing_bytes.size() > 0 || i_valid || expected_frame_bytes.size() > 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input int value);
        wait_idle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value[16:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int limits[PHASE_COUNT];
        limits = '{24, 0, 131071, 100, 0, 0, 16380, 65558};
        limits[4] = $urandom_range(24, 600);
        limits[5] = $urandom_range(0, 131071);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset limit; near-miss syncs, a minimal frame, then a stale sync tail
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(SYNC_A);
        push_byte(SYNC_B);
        push_byte(8'h00);
        push_byte(SYNC_A);
        push_frame(0, MAX_LEN_RST);
        void'(outgoing_bytes.pop_back());
        void'(outgoing_bytes.pop_back());
        push_byte(SYNC_A);
        push_byte(SYNC_B);
        push_byte(SYNC_C);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_limit(limits[p]);
            phase_items = 0;
            // finish the header left open by the previous phase under the new limit
            if (p == 3) push_header_span(13, IDX_HDR_LAST, PARTIAL_LEN);
            while (phase_items < PHASE_ITEMS) push_random_traffic(limits[p]);
            if (p == 2) begin
                push_byte(SYNC_A);
                push_byte(SYNC_B);
                push_byte(SYNC_C);
                push_header_span(3, 12, PARTIAL_LEN);
            end
            // largest length field, one above the limit
            if (p == PHASE_COUNT - 1) push_frame(65535, limits[p]);
        end

        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("%0d stream bytes sent, %0d frame bytes checked over %0d limit settings",
                 bytes_sent, frame_bytes_checked, limit_writes + 1);
        $display("%0d frames closed, %0d of them by a length error", frames_closed, length_errors);
        if (failures == 0 && expected_frame_bytes.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
